### rtl/core/sfla_pkg.sv
// Shared types, field widths and codes for the slab free-list allocator.
`timescale 1ns / 1ps

package sfla_pkg;

   localparam int STACK_DEPTH_DEF = 1024;

   localparam int ADDR_W      = 32;
   localparam int OBJ_W       = 17;
   localparam int SLOTS_W     = 11;
   localparam int SIZE_W      = 18;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 3;
   localparam int IDX_OUT_W   = 10;
   localparam int LEFT_W      = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int RSP_W       = STATUS_W + ADDR_W + IDX_OUT_W + LEFT_W;

   // slot sizes are whole multiples of eight bytes
   localparam int ALIGN_SHIFT = 3;
   localparam int DVD_W       = ADDR_W - ALIGN_SHIFT;
   localparam int DVS_W       = SIZE_W - ALIGN_SHIFT;

   localparam logic [OBJ_W-1:0]   OBJ_BYTES_RST = OBJ_W'(8);
   localparam logic [SLOTS_W-1:0] SLOT_COUNT_RST = SLOTS_W'(1024);
   localparam logic [ADDR_W-1:0]  BASE_ADDR_RST = '0;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_INIT  = 2'd2,
      CMD_NOP   = 2'd3
   } sfla_cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_EMPTY      = 3'd1,
      ST_MISALIGNED = 3'd2,
      ST_RANGE      = 3'd3,
      ST_FULL       = 3'd4
   } sfla_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OBJECT_BYTES = 2'd0,
      CSR_SLOT_COUNT   = 2'd1,
      CSR_BASE_ADDRESS = 2'd2
   } sfla_csr_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_ALLOC_MUL,
      ENG_ALLOC_ADD,
      ENG_FREE_WAIT,
      ENG_INIT_FILL,
      ENG_DONE
   } sfla_state_type;

   typedef struct packed {
      logic [OBJ_W-1:0]   object_bytes;
      logic [SLOTS_W-1:0] slot_count;
      logic [ADDR_W-1:0]  base_address;
   } sfla_cfg_type;

   typedef struct packed {
      sfla_status_type      status;
      logic [ADDR_W-1:0]    slot_address;
      logic [IDX_OUT_W-1:0] slot_index;
      logic [LEFT_W-1:0]    free_left;
   } sfla_result_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } sfla_div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } sfla_div_rsp_type;

endpackage

### rtl/core/sfla_stack_ram.sv
// Single-port synchronous RAM holding the free slot index stack.
`timescale 1ns / 1ps

module sfla_stack_ram import sfla_pkg::*; #(
   parameter int DEPTH = STACK_DEPTH_DEF,
   parameter int WIDTH = $clog2(STACK_DEPTH_DEF)
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         q
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= mem_ff[addr];
   end

   assign q = q_ff;

endmodule

### rtl/core/sfla_div.sv
// Restoring divider, one quotient bit per cycle, for address-to-slot mapping.
`timescale 1ns / 1ps

module sfla_div import sfla_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  sfla_div_req_type req,
   output sfla_div_rsp_type rsp
);

   localparam int STEP_W = $clog2(DVD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0]  quot_ff, quot_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;

   logic [DVS_W:0]    rem_sh;
   logic              fits;

   always_comb begin
      rem_sh  = {rem_ff, quot_ff[DVD_W-1]};
      fits    = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_W'(DVD_W - 1);
         quot_in = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DVD_W-2:0], fits};
         rem_in  = fits ? DVS_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DVS_W-1:0];
         cnt_in  = cnt_ff - STEP_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quot_ff;
   assign rsp.remainder = rem_ff;

endmodule

### rtl/core/sfla_engine.sv
// Command sequencer: stack pointer, pops, pushes, refill sweep and result build.
`timescale 1ns / 1ps

module sfla_engine import sfla_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   localparam int IDX_W = $clog2(STACK_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  sfla_cfg_type      cfg,
   input  logic              start,
   input  sfla_cmd_type      cmd,
   input  logic [ADDR_W-1:0] free_address,
   output logic              ready,
   output logic              res_valid,
   input  logic              res_take,
   output sfla_result_type   res,
   output sfla_div_req_type  div_req,
   input  sfla_div_rsp_type  div_rsp,
   output logic              ram_we,
   output logic [IDX_W-1:0]  ram_addr,
   output logic [IDX_W-1:0]  ram_wdata,
   input  logic [IDX_W-1:0]  ram_q
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int PROD_W = IDX_W + SIZE_W;

   sfla_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  ft_ff, ft_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [ADDR_W-1:0] faddr_ff, faddr_in;
   sfla_result_type   res_ff, res_in;

   logic [SIZE_W-1:0] size_raw, size;
   logic [CNT_W-1:0]  cap;
   logic [ADDR_W-1:0] offset;

   // slot size rounded up to eight, zero taken as eight
   always_comb begin
      size_raw = (SIZE_W'(cfg.object_bytes) + SIZE_W'(7)) & ~SIZE_W'(7);
      size     = (size_raw == '0) ? SIZE_W'(8) : size_raw;
      if (ADDR_W'(cfg.slot_count) > ADDR_W'(STACK_DEPTH)) begin
         cap = CNT_W'(STACK_DEPTH);
      end else begin
         cap = CNT_W'(cfg.slot_count);
      end
      offset = free_address - cfg.base_address;
   end

   always_comb begin
      state_in  = state_ff;
      ft_in     = ft_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      prod_in   = prod_ff;
      faddr_in  = faddr_ff;
      res_in    = res_ff;
      ram_we    = 1'b0;
      ram_addr  = IDX_W'(ft_ff);
      ram_wdata = IDX_W'(div_rsp.quotient);
      div_req.start    = 1'b0;
      div_req.dividend = offset[ADDR_W-1:ALIGN_SHIFT];
      div_req.divisor  = size[SIZE_W-1:ALIGN_SHIFT];

      case (state_ff)
         ENG_IDLE: begin
            res_in = '{status: ST_OK, slot_address: '0, slot_index: '0,
                       free_left: LEFT_W'(ft_ff)};
            if (start) begin
               case (cmd)
                  CMD_ALLOC: begin
                     if (ft_ff == '0) begin
                        res_in.status = ST_EMPTY;
                        state_in      = ENG_DONE;
                     end else begin
                        // pop: read top entry, result lands next cycle
                        ft_in    = ft_ff - CNT_W'(1);
                        ram_addr = IDX_W'(ft_ff - CNT_W'(1));
                        state_in = ENG_ALLOC_MUL;
                     end
                  end
                  CMD_FREE: begin
                     faddr_in = free_address;
                     if (offset[ALIGN_SHIFT-1:0] != '0) begin
                        res_in.status = ST_MISALIGNED;
                        state_in      = ENG_DONE;
                     end else begin
                        div_req.start = 1'b1;
                        state_in      = ENG_FREE_WAIT;
                     end
                  end
                  CMD_INIT: begin
                     fill_in = '0;
                     if (cap == '0) begin
                        ft_in            = '0;
                        res_in.free_left = '0;
                        state_in         = ENG_DONE;
                     end else begin
                        state_in = ENG_INIT_FILL;
                     end
                  end
                  default: begin
                     state_in = ENG_DONE;
                  end
               endcase
            end
         end

         ENG_ALLOC_MUL: begin
            idx_in   = ram_q;
            prod_in  = PROD_W'(ram_q) * PROD_W'(size);
            state_in = ENG_ALLOC_ADD;
         end

         ENG_ALLOC_ADD: begin
            res_in = '{status: ST_OK,
                       slot_address: cfg.base_address + ADDR_W'(prod_ff),
                       slot_index: IDX_OUT_W'(idx_ff),
                       free_left: LEFT_W'(ft_ff)};
            state_in = ENG_DONE;
         end

         ENG_FREE_WAIT: begin
            if (div_rsp.done) begin
               state_in = ENG_DONE;
               if (div_rsp.remainder != '0) begin
                  res_in.status = ST_MISALIGNED;
               end else if (ADDR_W'(div_rsp.quotient) >= ADDR_W'(cap)) begin
                  res_in.status = ST_RANGE;
               end else if (ft_ff >= cap) begin
                  res_in.status = ST_FULL;
               end else begin
                  // push; address maps back exactly to the freed address
                  ram_we = 1'b1;
                  ft_in  = ft_ff + CNT_W'(1);
                  res_in = '{status: ST_OK, slot_address: faddr_ff,
                             slot_index: IDX_OUT_W'(div_rsp.quotient),
                             free_left: LEFT_W'(ft_ff + CNT_W'(1))};
               end
            end
         end

         ENG_INIT_FILL: begin
            ram_we    = 1'b1;
            ram_addr  = IDX_W'(fill_ff);
            ram_wdata = IDX_W'(cap - CNT_W'(1) - fill_ff);
            fill_in   = fill_ff + CNT_W'(1);
            if (fill_ff == cap - CNT_W'(1)) begin
               ft_in            = cap;
               res_in.free_left = LEFT_W'(cap);
               state_in         = ENG_DONE;
            end
         end

         ENG_DONE: begin
            if (res_take) begin
               state_in = ENG_IDLE;
            end
         end

         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         ft_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ft_ff    <= ft_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_ff  <= fill_in;
      idx_ff   <= idx_in;
      prod_ff  <= prod_in;
      faddr_ff <= faddr_in;
      res_ff   <= res_in;
   end

   assign ready     = (state_ff == ENG_IDLE);
   assign res_valid = (state_ff == ENG_DONE);
   assign res       = res_ff;

endmodule

### rtl/core/slab_free_list_allocator.sv
// Top level of the slab free-list allocator: CSRs, stream ports, output register.
`timescale 1ns / 1ps

// Channel  Dir  Ports                         Contents
// req      in   req_tvalid/tready/tdata/tuser one command; tuser = cmd, tdata = free_address
// rsp      out  rsp_tvalid/tready/tdata       one result per request
// csr      in   csr_we/index/wdata            register write, no read-back
//
// One request at a time. Allocate runs from accept through stack RAM read, multiply, add
// and hand-off. Free waits on a 29-step one-bit-per-cycle divider that maps the address
// to a slot. Init sweeps the stack RAM one entry per cycle. Empty allocate, a free
// misaligned in its low three bits and the unused command go straight to the result.
// Reset clears the free count to zero (allocate answers empty); stack contents are
// undefined until init or free writes them. A stalled rsp side holds one result in the
// output register and one in the sequencer.

module slab_free_list_allocator import sfla_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ADDR_W-1:0]     req_tdata,   // [31:0] free_address
   input  logic [CMD_W-1:0]      req_tuser,   // [1:0] cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // [2:0] status, [34:3] slot_address,
                                              // [44:35] slot_index, [55:45] free_left
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(STACK_DEPTH);

   sfla_cfg_type     cfg_ff, cfg_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   sfla_result_type  rsp_ff, rsp_in;

   logic             eng_ready;
   logic             eng_res_valid;
   logic             eng_res_take;
   sfla_result_type  eng_res;
   sfla_div_req_type div_req;
   sfla_div_rsp_type div_rsp;
   logic             ram_we;
   logic [IDX_W-1:0] ram_addr;
   logic [IDX_W-1:0] ram_wdata;
   logic [IDX_W-1:0] ram_q;
   logic             req_fire;

   // config registers, to be written only while idle; the block itself does not enforce this
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (sfla_csr_type'(csr_index))
            CSR_OBJECT_BYTES: cfg_in.object_bytes = csr_wdata[OBJ_W-1:0];
            CSR_SLOT_COUNT:   cfg_in.slot_count   = csr_wdata[SLOTS_W-1:0];
            CSR_BASE_ADDRESS: cfg_in.base_address = csr_wdata[ADDR_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.object_bytes <= OBJ_BYTES_RST;
         cfg_ff.slot_count   <= SLOT_COUNT_RST;
         cfg_ff.base_address <= BASE_ADDR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = eng_ready;
   assign req_fire   = req_tvalid && eng_ready;

   sfla_engine #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .start        (req_fire),
      .cmd          (sfla_cmd_type'(req_tuser)),
      .free_address (req_tdata),
      .ready        (eng_ready),
      .res_valid    (eng_res_valid),
      .res_take     (eng_res_take),
      .res          (eng_res),
      .div_req      (div_req),
      .div_rsp      (div_rsp),
      .ram_we       (ram_we),
      .ram_addr     (ram_addr),
      .ram_wdata    (ram_wdata),
      .ram_q        (ram_q)
   );

   sfla_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   sfla_stack_ram #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (IDX_W)
   ) u_stack_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .q     (ram_q)
   );

   // output register: loads when empty or being drained
   assign eng_res_take = eng_res_valid && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_in        = rsp_ff;
      if (eng_res_take) begin
         rsp_tvalid_in = 1'b1;
         rsp_in        = eng_res;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_ff.free_left, rsp_ff.slot_index, rsp_ff.slot_address,
                        rsp_ff.status};

`ifndef SYNTHESIS
   // a new request is never taken while one is in flight
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while sequencer busy");

   // a result blocked behind a full output register stays in the sequencer
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      eng_res_valid && rsp_tvalid_ff && !rsp_tready |=> eng_res_valid && rsp_tvalid_ff)
      else $error("result dropped while output stalled");

   // rejected requests carry no slot
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_ff.status != ST_OK
         |-> rsp_ff.slot_address == '0 && rsp_ff.slot_index == '0)
      else $error("rejected request reports a slot");

   // free count never exceeds the stack depth
   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> 32'(rsp_ff.free_left) <= 32'(STACK_DEPTH))
      else $error("free count above stack depth");
`endif

endmodule

### tb/testbench.sv
// Testbench for the slab free-list allocator: directed corners, then random traffic.
`timescale 1ns / 1ps

module testbench;
   import sfla_pkg::*;

   // A free waits on the divider and a full-depth init sweeps every stack entry;
   // the watchdog only trips when no handshake happens for far longer than either.
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int END_MARGIN     = 1100;

   // bit positions of the result fields inside rsp_tdata
   localparam int ADDR_LSB  = STATUS_W;
   localparam int INDEX_LSB = STATUS_W + ADDR_W;
   localparam int LEFT_LSB  = INDEX_LSB + IDX_OUT_W;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [ADDR_W-1:0]     req_tdata;   // [31:0] free_address
   logic [CMD_W-1:0]      req_tuser;   // [1:0] cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_W-1:0]      rsp_tdata;   // [2:0] status, [34:3] slot_address,
                                       // [44:35] slot_index, [55:45] free_left
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   slab_free_list_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow of the allocator: register copies, free-slot stack, free count
   // ---------------------------------------------------------------------
   logic [OBJ_W-1:0]     cfg_object_bytes = OBJ_BYTES_RST;
   logic [SLOTS_W-1:0]   cfg_slot_count   = SLOT_COUNT_RST;
   logic [ADDR_W-1:0]    cfg_base         = BASE_ADDR_RST;
   logic [IDX_OUT_W-1:0] slot_stack [STACK_DEPTH_DEF];
   logic [LEFT_W-1:0]    shadow_left = '0;

   sfla_result_type pending_outcomes [$];   // predicted results, oldest first
   int              failures = 0;
   logic            no_idle_window = 1'b0;  // both sides run flat out while set

   // size rounds up to a multiple of eight; zero behaves as eight
   function automatic logic [SIZE_W-1:0] slot_size();
      logic [SIZE_W-1:0] rounded;
      rounded = ({1'b0, cfg_object_bytes} + SIZE_W'(7)) & ~SIZE_W'(7);
      return (rounded == '0) ? SIZE_W'(8) : rounded;
   endfunction

   // slot_count beyond the stack depth is clamped
   function automatic logic [SLOTS_W-1:0] capacity();
      return (cfg_slot_count > SLOTS_W'(STACK_DEPTH_DEF)) ? SLOTS_W'(STACK_DEPTH_DEF)
                                                         : cfg_slot_count;
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [31:0] idx);
      logic [63:0] span;
      span = 64'(idx) * 64'(slot_size());
      return cfg_base + span[ADDR_W-1:0];
   endfunction

   // Applies one request to the shadow state and returns what the block must answer.
   function automatic sfla_result_type compute_slot_result(input sfla_cmd_type cmd,
                                                           input logic [ADDR_W-1:0] faddr);
      sfla_result_type   res;
      logic [SIZE_W-1:0]  size;
      logic [SLOTS_W-1:0] cap;
      logic [31:0]        offset;
      logic [31:0]        idx;
      int                 i;
      size = slot_size();
      cap = capacity();
      res.status = ST_OK;
      res.slot_address = '0;
      res.slot_index = '0;
      case (cmd)
         CMD_ALLOC: begin
            if (shadow_left == '0) begin
               res.status = ST_EMPTY;
            end else begin
               shadow_left = shadow_left - LEFT_W'(1);
               idx = 32'(slot_stack[shadow_left[IDX_OUT_W-1:0]]);
               res.slot_address = slot_addr(idx);
               res.slot_index = idx[IDX_OUT_W-1:0];
            end
         end
         CMD_FREE: begin
            // alignment first, then range, then room on the stack
            offset = faddr - cfg_base;
            idx = offset / 32'(size);
            if (offset % 32'(size) != 0) begin
               res.status = ST_MISALIGNED;
            end else if (idx >= 32'(cap)) begin
               res.status = ST_RANGE;
            end else if (shadow_left >= LEFT_W'(cap)) begin
               res.status = ST_FULL;
            end else begin
               slot_stack[shadow_left[IDX_OUT_W-1:0]] = idx[IDX_OUT_W-1:0];
               shadow_left = shadow_left + LEFT_W'(1);
               res.slot_address = slot_addr(idx);
               res.slot_index = idx[IDX_OUT_W-1:0];
            end
         end
         CMD_INIT: begin
            // slot 0 ends up on top of the stack
            for (i = 0; i < int'(cap); i++)
               slot_stack[i] = IDX_OUT_W'(int'(cap) - 1 - i);
            shadow_left = LEFT_W'(cap);
         end
         default: ;
      endcase
      res.free_left = shadow_left;
      return res;
   endfunction

   function automatic int draw_wait();
      if (no_idle_window)
         return 0;
      return $urandom_range(0, 8);
   endfunction

   // in a loop, redraw whether the next stretch runs with no idling (one chance in four)
   always begin
      repeat (200) @(posedge clock);
      no_idle_window <= ($urandom_range(0, 3) == 0);
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Leaves req_tvalid high after acceptance so back-to-back requests never
   // lower and raise it in the same step; wait_drained drops it.
   task automatic send_request(input sfla_cmd_type cmd, input logic [ADDR_W-1:0] addr,
                               output sfla_result_type predicted);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= addr;
      predicted = compute_slot_result(cmd, addr);
      pending_outcomes.push_back(predicted);
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   // Stop requesting and wait until every predicted result has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
   endtask

   // Only called with the block idle. Writes all three registers in turn.
   task automatic set_config(input logic [OBJ_W-1:0] obj, input logic [SLOTS_W-1:0] slots,
                             input logic [ADDR_W-1:0] base);
      csr_we <= 1'b1;
      csr_index <= CSR_OBJECT_BYTES;
      csr_wdata <= CSR_DATA_W'(obj);
      @(posedge clock);
      csr_index <= CSR_SLOT_COUNT;
      csr_wdata <= CSR_DATA_W'(slots);
      @(posedge clock);
      csr_index <= CSR_BASE_ADDRESS;
      csr_wdata <= base;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_object_bytes = obj;
      cfg_slot_count = slots;
      cfg_base = base;
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stalls, field-by-field compare with the oldest prediction
   // ---------------------------------------------------------------------
   initial begin : result_checker
      sfla_result_type       want;
      logic [STATUS_W-1:0]   got_status;
      logic [ADDR_W-1:0]     got_addr;
      logic [IDX_OUT_W-1:0]  got_index;
      logic [LEFT_W-1:0]     got_left;
      int                    stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got_status = rsp_tdata[STATUS_W-1:0];
         got_addr   = rsp_tdata[ADDR_LSB +: ADDR_W];
         got_index  = rsp_tdata[INDEX_LSB +: IDX_OUT_W];
         got_left   = rsp_tdata[LEFT_LSB +: LEFT_W];
         if (pending_outcomes.size() == 0) begin
            $error("result with no request outstanding: tdata %h", rsp_tdata);
            failures++;
         end else begin
            want = pending_outcomes.pop_front();
            if (got_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got_status);
               failures++;
            end
            if (got_addr !== want.slot_address) begin
               $error("slot_address: expected %h, got %h", want.slot_address, got_addr);
               failures++;
            end
            if (got_index !== want.slot_index) begin
               $error("slot_index: expected %0d, got %0d", want.slot_index, got_index);
               failures++;
            end
            if (got_left !== want.free_left) begin
               $error("free_left: expected %0d, got %0d", want.free_left, got_left);
               failures++;
            end
         end
      end
   end

   // Watchdog: cycles with no handshake on either channel
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Reset values in force, no init yet: allocate is empty, a good free still pushes.
   task automatic test_alloc_before_init();
      sfla_result_type outcome;
      send_request(CMD_ALLOC, '0, outcome);
      send_request(CMD_FREE, 32'h0000_0010, outcome);        // slot 2 goes on the stack
      send_request(CMD_FREE, 32'h0000_0013, outcome);        // misaligned
      send_request(CMD_FREE, 32'h0000_2000, outcome);        // slot 1024, out of range
      send_request(CMD_FREE, 32'hFFFF_FFFF, outcome);        // all ones, misaligned
      send_request(CMD_NOP, 32'hA5A5_5A5A, outcome);         // unused command
      send_request(CMD_ALLOC, 32'hFFFF_FFFF, outcome);       // pops slot 2
      send_request(CMD_ALLOC, '0, outcome);                  // empty again
      wait_drained();
   endtask

   // Three 24-byte slots just below the top of the address space: addresses wrap,
   // the pool runs empty, and range wins over full.
   task automatic test_small_pool_wrap();
      sfla_result_type outcome;
      set_config(OBJ_W'(24), SLOTS_W'(3), 32'hFFFF_FFF0);
      send_request(CMD_INIT, '0, outcome);
      send_request(CMD_FREE, cfg_base, outcome);             // full: all three free
      send_request(CMD_FREE, slot_addr(3), outcome);         // range before full
      repeat (4) send_request(CMD_ALLOC, '0, outcome);       // 0, 1, 2, then empty
      send_request(CMD_FREE, 32'h0000_0008, outcome);        // slot 1 via wrapped address
      send_request(CMD_FREE, cfg_base + 1, outcome);
      wait_drained();
   endtask

   // Size rounding, capacity lowered under a live stack, zero and clamped capacity.
   task automatic test_capacity_corners();
      sfla_result_type outcome;
      set_config('0, SLOTS_W'(4), '0);                       // size zero acts as eight
      send_request(CMD_INIT, '0, outcome);
      wait_drained();
      set_config('0, SLOTS_W'(2), '0);                       // four free, capacity two
      send_request(CMD_FREE, 32'h0000_0008, outcome);        // full
      send_request(CMD_ALLOC, '0, outcome);                  // popping still works
      send_request(CMD_FREE, 32'h0000_0018, outcome);        // slot 3 now out of range
      wait_drained();
      set_config(OBJ_W'(13), '0, '0);                        // rounds to 16; no slots
      send_request(CMD_INIT, '0, outcome);
      send_request(CMD_FREE, '0, outcome);
      send_request(CMD_ALLOC, '0, outcome);
      wait_drained();
      // largest field values: size rounds to 128K, count clamps to the depth
      set_config({OBJ_W{1'b1}}, {SLOTS_W{1'b1}}, 32'hFFFF_FFFF);
      send_request(CMD_INIT, '0, outcome);
      send_request(CMD_ALLOC, '0, outcome);
      send_request(CMD_FREE, slot_addr(1023), outcome);
      send_request(CMD_FREE, '0, outcome);
      wait_drained();
   endtask

   // Mostly matched allocate/free traffic on a fresh pool, with bad frees,
   // double frees, stray commands and the odd re-init mixed in.
   task automatic test_random_traffic(input int n_items, input logic [OBJ_W-1:0] obj,
                                      input logic [SLOTS_W-1:0] slots,
                                      input logic [ADDR_W-1:0] base);
      sfla_result_type      outcome;
      logic [IDX_OUT_W-1:0] held_slots [$];
      int                   roll;
      int                   pick;
      logic [31:0]          idx;
      set_config(obj, slots, base);
      send_request(CMD_INIT, '0, outcome);
      for (int n = 0; n < n_items; n++) begin
         roll = $urandom_range(0, 99);
         if (roll >= 45 && roll < 80 && held_slots.size() > 0) begin
            pick = $urandom_range(0, held_slots.size() - 1);
            idx = 32'(held_slots[pick]);
            held_slots.delete(pick);
            send_request(CMD_FREE, slot_addr(idx), outcome);
         end else if (roll < 80) begin
            send_request(CMD_ALLOC, $urandom(), outcome);
            if (outcome.status == ST_OK)
               held_slots.push_back(outcome.slot_index);
         end else if (roll < 84) begin
            idx = $urandom_range(0, int'(capacity()));
            send_request(CMD_FREE, slot_addr(idx) + $urandom_range(1, int'(slot_size()) - 1),
                         outcome);
         end else if (roll < 88) begin
            idx = 32'(capacity()) + $urandom_range(0, 255);
            send_request(CMD_FREE, slot_addr(idx), outcome);
         end else if (roll < 92) begin
            // possibly a double free; may hit a full stack
            idx = $urandom_range(0, int'(capacity()) - 1);
            send_request(CMD_FREE, slot_addr(idx), outcome);
         end else if (roll < 96) begin
            send_request(CMD_FREE, $urandom(), outcome);
         end else if (roll < 98 || capacity() > SLOTS_W'(64)) begin
            send_request(CMD_NOP, $urandom(), outcome);
         end else begin
            send_request(CMD_INIT, $urandom(), outcome);
            held_slots.delete();
         end
      end
      wait_drained();
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= CMD_ALLOC;
      csr_we <= 1'b0;
      csr_index <= CSR_OBJECT_BYTES;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_alloc_before_init();
      test_small_pool_wrap();
      test_capacity_corners();
      test_random_traffic(250, OBJ_W'(8), SLOTS_W'(8), '0);
      test_random_traffic(250, OBJ_W'(65536), SLOTS_W'(16), 32'hFFFF_0000);
      test_random_traffic(250, OBJ_W'($urandom_range(1, 8192) * 8),
                          SLOTS_W'($urandom_range(1, 32)), $urandom());
      test_random_traffic(250, OBJ_W'($urandom()), SLOTS_W'($urandom_range(1, 64)),
                          $urandom());
      test_random_traffic(150, OBJ_W'(8), SLOTS_W'(STACK_DEPTH_DEF), $urandom());

      // give a stray extra result time to show up
      wait_drained();
      repeat (END_MARGIN) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         $error("%0d results never arrived", pending_outcomes.size());
         failures++;
      end
      if (failures == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

### filelist.f
rtl/core/sfla_pkg.sv
rtl/core/sfla_stack_ram.sv
rtl/core/sfla_div.sv
rtl/core/sfla_engine.sv
rtl/core/slab_free_list_allocator.sv
tb/testbench.sv
